### rtl/core/mupl_pkg.sv
package mupl_pkg;

    localparam int SLOW_SLOTS_DEF = 5;
    localparam logic [7:0] OPC_SPEED   = 8'h20;
    localparam logic [7:0] OPC_CURRENT = 8'h0a;
    localparam logic [7:0] OPC_STATUS  = 8'h08;
    localparam logic [7:0] OPC_BATTERY = 8'h11;
    localparam logic [2:0] BATTERY_SLOT = 3'd3;
    localparam logic [15:0] AGE_NEVER = 16'hFFFF;

    localparam logic [1:0] FUNC_POLL = 2'd0;
    localparam logic [1:0] FUNC_RESP = 2'd1;
    localparam logic [1:0] FUNC_TICK = 2'd2;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    localparam logic [1:0] PSTAT_WAIT = 2'd0;
    localparam logic [1:0] PSTAT_READY = 2'd1;
    localparam logic [1:0] PSTAT_SUPP = 2'd2;

    localparam logic [1:0] KIND_SPEED = 2'd0;
    localparam logic [1:0] KIND_CURRENT = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;
    localparam logic [1:0] KIND_BATTERY = 2'd3;

    localparam logic [1:0] LINK_UNKNOWN = 2'd0;
    localparam logic [1:0] LINK_OK = 2'd1;
    localparam logic [1:0] LINK_STALE = 2'd2;
    localparam logic [1:0] LINK_LOST = 2'd3;

    localparam logic [1:0] CFG_PERIM = 2'd0;
    localparam logic [1:0] CFG_TIMEOUT = 2'd1;
    localparam logic [1:0] CFG_STALE = 2'd2;
    localparam logic [1:0] CFG_LOST = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_MUL,
        ST_DIV,
        ST_AGE,
        ST_TOUT,
        ST_OUT
    } mupl_state_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic mul;
        logic div;
        logic age;
        logic tout;
    } mupl_cmd_t;

    typedef struct packed {
        logic speed_ok;
        logic is_tick;
    } mupl_stat_t;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] resp_byte0;
        logic [7:0] resp_byte1;
        logic [7:0] resp_byte2;
        logic [1:0] resp_len;
        logic [15:0] tick_ms;
    } mupl_in_t;

    typedef struct packed {
        logic [1:0] poll_status;
        logic [7:0] req_opcode;
        logic accepted;
        logic [15:0] wheel_rpm;
        logic [15:0] speed_dkph;
        logic [9:0] current_x10;
        logic [7:0] ctrl_status;
        logic [6:0] battery_soc;
        logic [7:0] battery_raw;
        logic [4:0] valid_mask;
        logic [1:0] link_code;
        logic [7:0] telemetry_age;
    } mupl_out_t;

endpackage

### rtl/core/mupl_if.sv
interface mupl_in_if import mupl_pkg::*; ();
    logic valid;
    logic ready;
    mupl_in_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface mupl_out_if import mupl_pkg::*; ();
    logic valid;
    logic ready;
    mupl_out_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### rtl/core/mupl_ctrl.sv
module mupl_ctrl import mupl_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  mupl_stat_t stat,
    output mupl_cmd_t  cmd
);
    mupl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (in_valid) state_next = ST_EXEC;
            ST_EXEC:
            begin
                if (stat.is_tick) state_next = ST_AGE;
                else if (stat.speed_ok) state_next = ST_MUL;
                else state_next = ST_OUT;
            end
            ST_MUL:  state_next = ST_DIV;
            ST_DIV:  state_next = ST_OUT;
            ST_AGE:  state_next = ST_TOUT;
            ST_TOUT: state_next = ST_OUT;
            ST_OUT:  if (out_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_EXEC: cmd.exec = 1'b1;
            ST_MUL:  cmd.mul = 1'b1;
            ST_DIV:  cmd.div = 1'b1;
            ST_AGE:  cmd.age = 1'b1;
            ST_TOUT: cmd.tout = 1'b1;
            ST_OUT:  out_valid = 1'b1;
            default: ;
        endcase
    end

    a_single_phase: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid)) else $error("accept while result held");
    a_load_next: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> cmd.exec) else $error("load not followed by execute");
    a_div_after_mul: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mul |=> cmd.div) else $error("divide step skipped");
endmodule

### rtl/core/mupl_dp.sv
module mupl_dp import mupl_pkg::*; #(
    parameter int SLOW_SLOTS = SLOW_SLOTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  mupl_in_t    in_data,
    input  mupl_cmd_t   cmd,
    output mupl_stat_t  stat,
    output mupl_out_t   out_data
);
    localparam int SW = (SLOW_SLOTS > 1) ? $clog2(SLOW_SLOTS) : 1;
    localparam logic [SW:0] SLOT_LAST = (SW + 1)'(SLOW_SLOTS - 1);
    localparam logic [SW:0] BAT_SLOT = (SW + 1)'(BATTERY_SLOT);
    localparam bit HAS_BAT = SLOW_SLOTS > 3;

    logic [12:0] perim_reg;
    logic [15:0] tout_cfg_reg, stale_cfg_reg;
    logic [7:0]  lost_cfg_reg;
    mupl_in_t    in_reg;
    logic        waiting_reg;
    logic [1:0]  kind_reg, phase_reg;
    logic [SW-1:0] slot_reg;
    logic [15:0] reply_age_reg;
    logic [7:0]  tcount_reg;
    logic [15:0] fage_reg [4];
    logic [15:0] sraw_reg, speed_reg;
    logic [9:0]  cur_reg;
    logic [7:0]  status_reg, braw_reg;
    logic [6:0]  soc_reg;
    logic [4:0]  valid_reg;
    logic [1:0]  link_reg;
    logic [7:0]  age_reg;
    logic [1:0]  pstat_reg;
    logic [7:0]  opc_reg;
    logic        acc_reg;
    logic [31:0] prod_reg;
    logic [30:0] qn_reg;

    logic [7:0] b0, b1, b2;
    logic [1:0] rl;
    logic       speed_ok, cur_ok, stat_ok, bat_fmt, bat_ok;
    logic [4:0] drop_mask;
    logic [16:0] ra_sum;
    logic [15:0] ra_new;
    logic [33:0] q_num;
    logic [15:0] q_val;
    logic [9:0]  age_inc;
    logic [9:0]  age_sum;
    logic [7:0]  cnt_new;

    assign b0 = in_reg.resp_byte0;
    assign b1 = in_reg.resp_byte1;
    assign b2 = in_reg.resp_byte2;
    assign rl = in_reg.resp_len;

    assign speed_ok = waiting_reg && kind_reg == KIND_SPEED && rl == 2'd3
                      && (b0 + b1 + OPC_SPEED) == b2;
    assign cur_ok = waiting_reg && kind_reg == KIND_CURRENT && rl == 2'd2
                    && b0 == b1 && b0 <= 8'd200;
    assign stat_ok = waiting_reg && kind_reg == KIND_STATUS && rl == 2'd1;
    assign bat_fmt = waiting_reg && kind_reg == KIND_BATTERY && rl == 2'd2 && b0 == b1;
    assign bat_ok = bat_fmt && b0 <= 8'd100;

    assign stat.speed_ok = in_reg.func == FUNC_RESP && speed_ok;
    assign stat.is_tick = in_reg.func == FUNC_TICK;

    // (raw*perim*3 + 2500) / 5000 with raw*perim < 2^29, so n < 2^31; q = (n*k)>>44
    // k = ceil(2^44/5000) gives exact quotient for n < 2^31
    assign q_num = {2'b00, prod_reg} * 34'd3 + 34'd2500;
    assign q_val = 16'(({33'd0, qn_reg} * 64'd3518437209) >> 44);

    assign age_inc = 10'((({16'd0, in_reg.tick_ms} + 32'd99) * 32'd5243) >> 19);
    assign age_sum = {2'b00, age_reg} + age_inc;

    assign ra_sum = {1'b0, reply_age_reg} + {1'b0, in_reg.tick_ms};
    assign ra_new = ra_sum[16] ? 16'hFFFF : ra_sum[15:0];
    assign cnt_new = (tcount_reg == 8'hFF) ? tcount_reg : tcount_reg + 8'd1;

    always_comb
    begin
        case (kind_reg)
            KIND_SPEED:   drop_mask = 5'h03;
            KIND_CURRENT: drop_mask = 5'h04;
            KIND_STATUS:  drop_mask = 5'h08;
            default:      drop_mask = 5'h10;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            perim_reg <= 13'd2050;
            tout_cfg_reg <= 16'd200;
            stale_cfg_reg <= 16'd2000;
            lost_cfg_reg <= 8'd3;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PERIM:   perim_reg <= cfg_data[12:0];
                CFG_TIMEOUT: tout_cfg_reg <= cfg_data;
                CFG_STALE:   stale_cfg_reg <= cfg_data;
                CFG_LOST:    lost_cfg_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load) in_reg <= in_data;
        if (cmd.exec) prod_reg <= {16'd0, b0, b1} * {19'd0, perim_reg};
        if (cmd.mul) qn_reg <= q_num[30:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            waiting_reg <= 1'b0; kind_reg <= KIND_SPEED; phase_reg <= 2'd0;
            slot_reg <= '0; reply_age_reg <= '0; tcount_reg <= '0;
            for (int i = 0; i < 4; i++) fage_reg[i] <= AGE_NEVER;
            sraw_reg <= '0; speed_reg <= '0; cur_reg <= '0; status_reg <= '0;
            soc_reg <= '0; braw_reg <= '0; valid_reg <= '0; link_reg <= LINK_UNKNOWN;
            age_reg <= '0; pstat_reg <= PSTAT_WAIT; opc_reg <= '0; acc_reg <= 1'b0;
        end
        else
        begin
            if (cmd.exec)
            begin
                acc_reg <= in_reg.func == FUNC_RESP
                           && (speed_ok || cur_ok || stat_ok || bat_ok);
                if (in_reg.func == FUNC_POLL && !waiting_reg)
                begin
                    phase_reg <= phase_reg + 2'd1;
                    if (phase_reg != 2'd3 ||
                        (HAS_BAT && {1'b0, slot_reg} == BAT_SLOT))
                    begin
                        pstat_reg <= PSTAT_READY;
                        waiting_reg <= 1'b1;
                        reply_age_reg <= '0;
                        kind_reg <= phase_reg;
                        case (phase_reg)
                            2'd0:    opc_reg <= OPC_SPEED;
                            2'd1:    opc_reg <= OPC_CURRENT;
                            2'd2:    opc_reg <= OPC_STATUS;
                            default: opc_reg <= OPC_BATTERY;
                        endcase
                    end
                    else
                    begin
                        pstat_reg <= PSTAT_SUPP;
                        opc_reg <= '0;
                    end
                    if (phase_reg == 2'd3)
                        slot_reg <= ({1'b0, slot_reg} == SLOT_LAST) ? '0 : slot_reg + 1'b1;
                end
                else
                begin
                    pstat_reg <= PSTAT_WAIT;
                    opc_reg <= '0;
                end
                if (in_reg.func == FUNC_RESP)
                begin
                    if (bat_fmt) braw_reg <= b0;
                    if (speed_ok) sraw_reg <= {b0, b1};
                    if (cur_ok)
                    begin
                        cur_reg <= 10'({2'b00, b0} * 10'd5);
                        valid_reg <= valid_reg | 5'h04;
                    end
                    if (stat_ok)
                    begin
                        status_reg <= b0;
                        valid_reg <= valid_reg | 5'h08;
                    end
                    if (bat_ok)
                    begin
                        soc_reg <= b0[6:0];
                        valid_reg <= valid_reg | 5'h10;
                    end
                    if (speed_ok) valid_reg <= valid_reg | 5'h03;
                    if (speed_ok || cur_ok || stat_ok || bat_ok)
                    begin
                        waiting_reg <= 1'b0;
                        reply_age_reg <= '0;
                        tcount_reg <= '0;
                        fage_reg[kind_reg] <= '0;
                        age_reg <= '0;
                        link_reg <= LINK_OK;
                    end
                end
            end
            if (cmd.div) speed_reg <= q_val;
            if (cmd.age)
            begin
                for (int i = 0; i < 4; i++)
                begin
                    if (fage_reg[i] != AGE_NEVER)
                    begin
                        fage_reg[i] <= ({1'b0, fage_reg[i]} + {1'b0, in_reg.tick_ms}
                                        > 17'hFFFF) ? 16'hFFFF
                                        : fage_reg[i] + in_reg.tick_ms;
                    end
                end
                if (age_reg != 8'hFF)
                    age_reg <= (age_sum > 10'd255) ? 8'hFF : age_sum[7:0];
                if (waiting_reg) reply_age_reg <= ra_new;
            end
            if (cmd.tout)
            begin
                logic [4:0] v;
                v = valid_reg;
                // a field that saturated on this tick reads 65535 and is stale too;
                // never-seen fields already have their bits clear
                if (fage_reg[0] >= stale_cfg_reg) v &= 5'h1C;
                if (fage_reg[1] >= stale_cfg_reg) v &= 5'h1B;
                if (fage_reg[2] >= stale_cfg_reg) v &= 5'h17;
                if (fage_reg[3] >= stale_cfg_reg) v &= 5'h0F;
                if (waiting_reg && reply_age_reg >= tout_cfg_reg)
                begin
                    v &= ~drop_mask;
                    waiting_reg <= 1'b0;
                    tcount_reg <= cnt_new;
                    if (cnt_new >= lost_cfg_reg)
                    begin
                        link_reg <= LINK_LOST;
                        v = '0;
                    end
                    else
                        link_reg <= LINK_STALE;
                end
                valid_reg <= v;
            end
        end
    end

    assign out_data.poll_status = pstat_reg;
    assign out_data.req_opcode = opc_reg;
    assign out_data.accepted = acc_reg;
    assign out_data.wheel_rpm = sraw_reg;
    assign out_data.speed_dkph = speed_reg;
    assign out_data.current_x10 = cur_reg;
    assign out_data.ctrl_status = status_reg;
    assign out_data.battery_soc = soc_reg;
    assign out_data.battery_raw = braw_reg;
    assign out_data.valid_mask = valid_reg;
    assign out_data.link_code = link_reg;
    assign out_data.telemetry_age = age_reg;

    a_soc_range: assert property (@(posedge clk) disable iff (!rst_n)
        soc_reg <= 7'd100) else $error("soc above 100");
    a_cur_range: assert property (@(posedge clk) disable iff (!rst_n)
        cur_reg <= 10'd1000) else $error("current above limit");
    a_lost_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.tout && waiting_reg && reply_age_reg >= tout_cfg_reg
        && cnt_new >= lost_cfg_reg |=> valid_reg == 5'd0)
        else $error("lost link kept valid fields");
endmodule

### rtl/core/motor_uart_poll_link_monitor.sv
// channel | dir | payload                        | handshake
// req     | in  | func, resp bytes, len, elapsed | valid/ready
// rsp     | out | poll status, telemetry, link   | valid/ready
// cfg     | in  | index 0..3, 16-bit data        | cfg_we only
//
// One transaction at a time. Polls, unused func and all but valid speed responses
// go from execute straight to the output state, which offers the result; a valid
// speed response passes the multiply and divide states first (product, scale and
// round, reciprocal divide), a tick the age and timeout states (age add, compare).
// A held result keeps req.ready low until it is taken.
// rst_n is asynchronous; state, config and link/telemetry registers return to defaults.
module motor_uart_poll_link_monitor import mupl_pkg::*; #(
    parameter int SLOW_SLOTS = SLOW_SLOTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    mupl_in_if.sink     req,
    mupl_out_if.source  rsp
);
    mupl_cmd_t  cmd;
    mupl_stat_t stat;

    // controller sequences load, execute and the multi-cycle steps
    mupl_ctrl u_ctrl (
        .clk, .rst_n,
        .in_valid(req.valid), .in_ready(req.ready),
        .out_valid(rsp.valid), .out_ready(rsp.ready),
        .stat, .cmd
    );

    // datapath holds all link and telemetry state
    mupl_dp #(.SLOW_SLOTS(SLOW_SLOTS)) u_dp (
        .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
        .in_data(req.data), .cmd, .stat, .out_data(rsp.data)
    );
endmodule
